@@ rtl/pwp_pkg.sv @@
// Shared constants and types for the pulse width to per-mille converter.
package pwp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int PW_W          = 16;
	localparam int DB_W          = 10;
	localparam int POS_W         = 11;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	localparam int unsigned PERMILLE = 1000;

	localparam logic [PW_W-1:0] LOW_RST  = 16'd1000;
	localparam logic [PW_W-1:0] HIGH_RST = 16'd2000;
	localparam logic [DB_W-1:0] DB_MAX   = 10'd999;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_WIDTH  = 3'd0,
		REG_HIGH_WIDTH = 3'd1,
		REG_DEAD_BAND  = 3'd2,
		REG_REVERSE    = 3'd3,
		REG_POS_ONLY   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [PW_W-1:0] low;
		logic [PW_W-1:0] high;
		logic [PW_W-1:0] mid;
		logic [PW_W-1:0] den_hi;
		logic [PW_W-1:0] den_lo;
		logic [PW_W-1:0] den_uni;
		logic            narrow;
		logic            rev;
		logic            uni;
	} front_cfg_t;

	typedef struct packed {
		logic neg;
		logic kill;
	} side_t;

endpackage

@@ rtl/pulse_width_to_permille.sv @@
// Top level of the pulse width to per-mille converter.
//
// Usage: each request on the pulse channel (pulse_valid, pulse_stall, pulse_width)
// carries one measured pulse width in microseconds; the position channel
// (position_valid, position_stall, position) returns one signed per-mille
// command for it, in request order. A request moves on a rising edge with
// valid high and stall low. Registers are written through cfg_valid/cfg_ready
// with cfg_index and cfg_data; cfg_ready is always high. Write only while idle.
// Takes one request per cycle unless position_stall holds the pipeline. The path
// has 2*FRAC_BITS+7 register stages: two bit-per-stage dividers (ratio and dead
// band rescale) plus input, select, band, multiply and output stages.
// When position_stall is high with a result waiting, the whole pipeline holds
// and pulse_stall is raised; no stage advances until it drops. Reset clears all
// valid bits and loads low 1000, high 2000, no dead band, forward, bipolar;
// derived configuration values are recomputed through registers after reset or a write.
module pulse_width_to_permille #(
	parameter int FRAC_BITS = pwp_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pulse_valid,
	output logic                                pulse_stall,
	input  logic [pwp_pkg::PW_W-1:0]            pulse_width,
	output logic                                position_valid,
	input  logic                                position_stall,
	output logic signed [pwp_pkg::POS_W-1:0]    position,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pwp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pwp_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pwp_pkg::*;

	localparam int PROD_W = FRAC_BITS + DB_W + 1;

	logic                 en;
	front_cfg_t           front_cfg;
	logic [FRAC_BITS-1:0] dbf;
	logic [FRAC_BITS:0]   band_den;

	logic                 fr_valid;
	logic [PW_W-1:0]      fr_num, fr_den;
	side_t                fr_side;

	logic                 ra_valid;
	logic [FRAC_BITS:0]   ra_quo;
	side_t                ra_side;

	logic                 bd_valid;
	logic [FRAC_BITS:0]   bd_num, bd_den;
	side_t                bd_side;

	logic                 rs_valid;
	logic [FRAC_BITS:0]   rs_quo;
	side_t                rs_side;

	logic                 v_s1, v_s2;
	logic [PROD_W-1:0]    prod_s1;
	side_t                side_s1;
	logic [POS_W-1:0]     pos_s2;
	logic [DB_W-1:0]      mag;

	assign en          = !(position_valid && position_stall);
	assign pulse_stall = !en;
	assign cfg_ready   = 1'b1;

	pwp_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_valid),
		.wr_index  (cfg_index),
		.wr_data   (cfg_data),
		.front_cfg (front_cfg),
		.dbf       (dbf),
		.band_den  (band_den)
	);

	pwp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (pulse_valid),
		.pulse_width (pulse_width),
		.front_cfg   (front_cfg),
		.out_valid   (fr_valid),
		.num         (fr_num),
		.den         (fr_den),
		.side        (fr_side)
	);

	// pulse ratio: FRAC_BITS+1 bit result, saturated at one
	pwp_fdiv #(.W(PW_W), .Q(FRAC_BITS)) u_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.num       (fr_num),
		.den       (fr_den),
		.in_side   (fr_side),
		.out_valid (ra_valid),
		.quo       (ra_quo),
		.out_side  (ra_side)
	);

	pwp_band #(.FRAC_BITS(FRAC_BITS)) u_band (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ra_valid),
		.ratio     (ra_quo),
		.in_side   (ra_side),
		.dbf       (dbf),
		.band_den  (band_den),
		.out_valid (bd_valid),
		.num       (bd_num),
		.den       (bd_den),
		.out_side  (bd_side)
	);

	// rescale past the dead band
	pwp_fdiv #(.W(FRAC_BITS+1), .Q(FRAC_BITS)) u_rescale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (bd_valid),
		.num       (bd_num),
		.den       (bd_den),
		.in_side   (bd_side),
		.out_valid (rs_valid),
		.quo       (rs_quo),
		.out_side  (rs_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= rs_valid;
			v_s2 <= v_s1;
		end
	end

	assign mag = prod_s1[FRAC_BITS+DB_W-1:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(rs_quo) * PROD_W'(PERMILLE);
			side_s1 <= rs_side;
			if (side_s1.kill) begin
				pos_s2 <= '0;
			end else if (side_s1.neg) begin
				pos_s2 <= '0 - {1'b0, mag};
			end else begin
				pos_s2 <= {1'b0, mag};
			end
		end
	end

	assign position_valid = v_s2;
	assign position       = pos_s2;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		position_valid |-> (position >= -11'sd1000) && (position <= 11'sd1000))
		else $error("position outside -1000..1000");

	a_uni_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		position_valid && front_cfg.uni |-> !position[POS_W-1])
		else $error("negative position in positive-only mode");

	a_narrow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		position_valid && front_cfg.narrow |-> position == '0)
		else $error("nonzero position with a narrow window");

	a_kill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s1 && side_s1.kill |=> position == '0)
		else $error("killed request gave a nonzero position");

endmodule

@@ rtl/pwp_cfg.sv @@
// Configuration registers and the values derived from them.
module pwp_cfg #(
	parameter int FRAC_BITS = pwp_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [pwp_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [pwp_pkg::CFG_DATA_W-1:0]    wr_data,
	output pwp_pkg::front_cfg_t               front_cfg,
	output logic [FRAC_BITS-1:0]              dbf,
	output logic [FRAC_BITS:0]                band_den
);
	import pwp_pkg::*;

	localparam int EST_PROD_W = FRAC_BITS + DB_W + 1;
	localparam int X_W        = FRAC_BITS + DB_W;
	localparam logic [FRAC_BITS:0] RECIP =
		(FRAC_BITS+1)'((64'd1 << (FRAC_BITS + DB_W)) / 64'(PERMILLE));
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [PW_W-1:0] low_q, high_q;
	logic [DB_W-1:0] band_q;
	logic            rev_q, uni_q;

	logic [PW_W-1:0] mid_q, den_hi_q, den_lo_q, den_uni_q;
	logic            narrow_q;
	logic [FRAC_BITS-1:0] est_q, dbf_q;
	logic [FRAC_BITS:0]   band_den_q;

	logic [PW_W:0]        span;
	logic [PW_W-1:0]      half;
	logic                 narrow_d;
	logic [DB_W-1:0]      db_sat;
	logic [EST_PROD_W-1:0] est_prod;
	logic [X_W-1:0]       x_full, est_scaled, est_rem;
	logic                 est_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_RST;
			high_q <= HIGH_RST;
			band_q <= '0;
			rev_q  <= 1'b0;
			uni_q  <= 1'b0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_LOW_WIDTH:  low_q  <= wr_data[PW_W-1:0];
				REG_HIGH_WIDTH: high_q <= wr_data[PW_W-1:0];
				REG_DEAD_BAND:  band_q <= wr_data[DB_W-1:0];
				REG_REVERSE:    rev_q  <= wr_data[0];
				REG_POS_ONLY:   uni_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// window geometry
	assign span     = {1'b0, high_q} - {1'b0, low_q};
	assign half     = span[PW_W:1];
	assign narrow_d = ({1'b0, high_q} < ({1'b0, low_q} + (PW_W+1)'(2)));

	always_ff @(posedge clk) begin
		narrow_q  <= narrow_d;
		mid_q     <= low_q + half;
		den_lo_q  <= half;
		den_hi_q  <= half + PW_W'(span[0]);
		den_uni_q <= span[PW_W-1:0];
	end

	// dead band in fixed point: reciprocal estimate, then one correction step
	assign db_sat     = (band_q > DB_MAX) ? DB_MAX : band_q;
	assign est_prod   = EST_PROD_W'(db_sat) * EST_PROD_W'(RECIP);
	assign x_full     = {db_sat, {FRAC_BITS{1'b0}}};
	assign est_scaled = X_W'(est_q) * X_W'(PERMILLE);
	assign est_rem    = x_full - est_scaled;
	assign est_fix    = (est_rem >= X_W'(PERMILLE));

	always_ff @(posedge clk) begin
		est_q      <= est_prod[FRAC_BITS+DB_W-1:DB_W];
		dbf_q      <= est_q + FRAC_BITS'(est_fix);
		band_den_q <= ONE - {1'b0, dbf_q};
	end

	always_comb begin
		front_cfg.low     = low_q;
		front_cfg.high    = high_q;
		front_cfg.mid     = mid_q;
		front_cfg.den_hi  = den_hi_q;
		front_cfg.den_lo  = den_lo_q;
		front_cfg.den_uni = den_uni_q;
		front_cfg.narrow  = narrow_q;
		front_cfg.rev     = rev_q;
		front_cfg.uni     = uni_q;
	end

	assign dbf      = dbf_q;
	assign band_den = band_den_q;

endmodule

@@ rtl/pwp_front.sv @@
// Input register and numerator/denominator selection for the first divide.
module pwp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [pwp_pkg::PW_W-1:0]     pulse_width,
	input  pwp_pkg::front_cfg_t          front_cfg,
	output logic                         out_valid,
	output logic [pwp_pkg::PW_W-1:0]     num,
	output logic [pwp_pkg::PW_W-1:0]     den,
	output pwp_pkg::side_t               side
);
	import pwp_pkg::*;

	logic            v_s1, v_s2;
	logic [PW_W-1:0] pw_s1;
	logic [PW_W-1:0] num_s2, den_s2;
	side_t           side_s2;

	logic            ge_mid;
	logic [PW_W-1:0] d_up, d_dn;
	logic [PW_W:0]   un_fwd, un_rev, un_num;
	logic            un_pos;
	logic [PW_W-1:0] num_d, den_d;
	side_t           side_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	assign ge_mid = (pw_s1 >= front_cfg.mid);
	assign d_up   = pw_s1 - front_cfg.mid;
	assign d_dn   = front_cfg.mid - pw_s1;
	assign un_fwd = {1'b0, pw_s1} - {1'b0, front_cfg.low};
	assign un_rev = {1'b0, front_cfg.high} - {1'b0, pw_s1};
	assign un_num = front_cfg.rev ? un_rev : un_fwd;
	assign un_pos = !un_num[PW_W] && (un_num != '0);

	always_comb begin
		if (front_cfg.uni) begin
			num_d       = un_num[PW_W-1:0];
			den_d       = front_cfg.den_uni;
			side_d.neg  = 1'b0;
			side_d.kill = front_cfg.narrow || !un_pos;
		end else begin
			num_d       = ge_mid ? d_up : d_dn;
			den_d       = ge_mid ? front_cfg.den_hi : front_cfg.den_lo;
			side_d.neg  = !ge_mid ^ front_cfg.rev;
			side_d.kill = front_cfg.narrow;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pw_s1   <= pulse_width;
			num_s2  <= num_d;
			den_s2  <= den_d;
			side_s2 <= side_d;
		end
	end

	assign out_valid = v_s2;
	assign num       = num_s2;
	assign den       = den_s2;
	assign side      = side_s2;

endmodule

@@ rtl/pwp_fdiv.sv @@
// Pipelined restoring fractional divider, one quotient bit per stage, saturating at one.
module pwp_fdiv #(
	parameter int W = 16,
	parameter int Q = pwp_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [W-1:0]   num,
	input  logic [W-1:0]   den,
	input  pwp_pkg::side_t in_side,
	output logic           out_valid,
	output logic [Q:0]     quo,
	output pwp_pkg::side_t out_side
);
	import pwp_pkg::*;

	localparam logic [Q:0] ONE = {1'b1, {Q{1'b0}}};

	logic         v_s    [Q+1];
	logic         sat_s  [Q+1];
	logic [W-1:0] rem_s  [Q+1];
	logic [W-1:0] den_s  [Q+1];
	logic [Q-1:0] quo_s  [Q+1];
	side_t        side_s [Q+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s[0]  <= (num >= den);
			rem_s[0]  <= num;
			den_s[0]  <= den;
			quo_s[0]  <= '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 1; k <= Q; k++) begin : g_step
		logic [W:0] r2;
		logic [W:0] diff;
		logic       ge;

		assign r2   = {rem_s[k-1], 1'b0};
		assign ge   = (r2 >= {1'b0, den_s[k-1]});
		assign diff = r2 - {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sat_s[k]  <= sat_s[k-1];
				rem_s[k]  <= ge ? diff[W-1:0] : r2[W-1:0];
				den_s[k]  <= den_s[k-1];
				quo_s[k]  <= {quo_s[k-1][Q-2:0], ge};
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[Q];
	assign quo       = sat_s[Q] ? ONE : {1'b0, quo_s[Q]};
	assign out_side  = side_s[Q];

endmodule

@@ rtl/pwp_band.sv @@
// Dead band stage: flags ratios inside the band to give zero and sets up the rescale divide.
module pwp_band #(
	parameter int FRAC_BITS = pwp_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [FRAC_BITS:0]   ratio,
	input  pwp_pkg::side_t       in_side,
	input  logic [FRAC_BITS-1:0] dbf,
	input  logic [FRAC_BITS:0]   band_den,
	output logic                 out_valid,
	output logic [FRAC_BITS:0]   num,
	output logic [FRAC_BITS:0]   den,
	output pwp_pkg::side_t       out_side
);
	import pwp_pkg::*;

	logic                 v_s1;
	logic [FRAC_BITS:0]   num_s1, den_s1;
	side_t                side_s1;
	logic [FRAC_BITS+1:0] diff;

	assign diff = {1'b0, ratio} - {2'b0, dbf};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1       <= diff[FRAC_BITS:0];
			den_s1       <= band_den;
			side_s1.neg  <= in_side.neg;
			side_s1.kill <= in_side.kill || diff[FRAC_BITS+1];
		end
	end

	assign out_valid = v_s1;
	assign num       = num_s1;
	assign den       = den_s1;
	assign out_side  = side_s1;

endmodule

@@ verif/pwp_position_checker.sv @@
// Checker for the pulse width converter: predicts each position and compares it in order.
`timescale 1ns / 100ps

module pwp_position_checker #(
	parameter int FRAC_BITS = pwp_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pulse_valid,
	input  logic                                pulse_stall,
	input  logic [pwp_pkg::PW_W-1:0]            pulse_width,
	input  logic                                position_valid,
	input  logic                                position_stall,
	input  logic signed [pwp_pkg::POS_W-1:0]    position,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [pwp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pwp_pkg::CFG_DATA_W-1:0]      cfg_data,
	output int                                  position_errors,
	output int                                  positions_pending
);
	import pwp_pkg::*;

	localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
	localparam longint unsigned PM  = 64'(PERMILLE);

	typedef struct packed {
		logic [PW_W-1:0] low;
		logic [PW_W-1:0] high;
		logic [DB_W-1:0] band;
		logic            rev;
		logic            uni;
	} scaling_t;

	scaling_t           scaling;
	logic [POS_W-1:0]   expected_positions[$];
	logic [POS_W-1:0]   want;
	int                 error_total;

	function automatic longint unsigned travel_ratio(longint unsigned num, longint unsigned den);
		longint unsigned r;
		r = (num << FRAC_BITS) / den;
		return (r > ONE) ? ONE : r;
	endfunction

	function automatic longint unsigned banded_magnitude(longint unsigned ratio,
			logic [DB_W-1:0] band);
		longint unsigned db;
		longint unsigned dbf;
		longint unsigned resc;
		db = (band > DB_MAX) ? 64'(DB_MAX) : 64'(band);
		dbf = (db << FRAC_BITS) / PM;
		if (ratio < dbf)
			return 0;
		resc = ((ratio - dbf) << FRAC_BITS) / (ONE - dbf);
		resc = (resc * PM) >> FRAC_BITS;
		return (resc > PM) ? PM : resc;
	endfunction

	function automatic logic [POS_W-1:0] predict_position(logic [PW_W-1:0] pw, scaling_t s);
		longint unsigned pwl;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned ratio;
		longint unsigned mag;
		longint          num;
		longint          den;
		logic            neg;
		pwl = 64'(pw);
		lo  = 64'(s.low);
		hi  = 64'(s.high);
		mag = 0;
		neg = 1'b0;
		if (hi >= lo + 2) begin
			if (!s.uni) begin
				mid = lo + (hi - lo) / 2;
				if (pwl >= mid) begin
					ratio = travel_ratio(pwl - mid, hi - mid);
				end else begin
					ratio = travel_ratio(mid - pwl, mid - lo);
					neg = 1'b1;
				end
				mag = banded_magnitude(ratio, s.band);
				if (s.rev)
					neg = !neg;
			end else begin
				den = longint'(hi - lo);
				num = longint'(pwl) - longint'(lo);
				if (s.rev)
					num = den - num;
				ratio = 0;
				if (num > 0)
					ratio = travel_ratio(unsigned'(num), unsigned'(den));
				mag = banded_magnitude(ratio, s.band);
			end
		end
		return neg ? POS_W'(-mag) : POS_W'(mag);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scaling = '{low: LOW_RST, high: HIGH_RST, band: '0, rev: 1'b0, uni: 1'b0};
			expected_positions.delete();
			error_total = 0;
			position_errors <= 0;
			positions_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_LOW_WIDTH:  scaling.low  = cfg_data;
					REG_HIGH_WIDTH: scaling.high = cfg_data;
					REG_DEAD_BAND:  scaling.band = cfg_data[DB_W-1:0];
					REG_REVERSE:    scaling.rev  = cfg_data[0];
					REG_POS_ONLY:   scaling.uni  = cfg_data[0];
					default: ;
				endcase
			end
			if (position_valid && !position_stall) begin
				if (expected_positions.size() == 0) begin
					$display("%0t position with no request outstanding: expected none, got %0d",
						$time, position);
					error_total++;
				end else begin
					want = expected_positions.pop_front();
					if (want !== position) begin
						$display("%0t position mismatch: expected %0d, got %0d",
							$time, $signed(want), position);
						error_total++;
					end
				end
			end
			if (pulse_valid && !pulse_stall)
				expected_positions.push_back(predict_position(pulse_width, scaling));
			position_errors <= error_total;
			positions_pending <= expected_positions.size();
		end
	end

endmodule

@@ verif/tb_pulse_width_to_permille.sv @@
// Testbench top for the pulse width converter: reset, register settings, requests, verdict.
`timescale 1ns / 100ps

module tb_pulse_width_to_permille;
	import pwp_pkg::*;

	localparam int PHASES         = 30;
	localparam int PHASE_REQUESTS = 55;
	localparam int PRESSURE_PHASE = 12;
	localparam int HOLD_CYCLES    = 200;
	localparam int DRAIN_CYCLES   = 60;
	localparam int CYCLE_LIMIT    = 500000;

	logic                      clk;
	logic                      arst_n;
	logic                      pulse_valid;
	logic                      pulse_stall;
	logic [PW_W-1:0]           pulse_width;
	logic                      position_valid;
	logic                      position_stall;
	logic signed [POS_W-1:0]   position;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	int  position_errors;
	int  positions_pending;
	int  cycle_count;
	bit  src_gaps_on;
	bit  sink_stalls_on;
	bit  long_hold_req;

	logic [PW_W-1:0] fixed_low[11]  = '{16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd0,
		16'd0, 16'd500, 16'd3000, 16'd1000, 16'd65533, 16'd0};
	logic [PW_W-1:0] fixed_high[11] = '{16'd2000, 16'd2000, 16'd2000, 16'd2000, 16'd65535,
		16'd65535, 16'd501, 16'd1000, 16'd1002, 16'd65535, 16'd2};
	logic [DB_W-1:0] fixed_band[11] = '{10'd0, 10'd0, 10'd100, 10'd999, 10'd1023,
		10'd0, 10'd0, 10'd0, 10'd500, 10'd0, 10'd1000};
	bit              fixed_rev[11]  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
		1'b0, 1'b1, 1'b0};
	bit              fixed_uni[11]  = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b1};

	logic [PW_W-1:0] directed_widths[15] = '{16'd0, 16'd65535, 16'd1000, 16'd2000, 16'd1500,
		16'd1499, 16'd1501, 16'd999, 16'd2001, 16'd1001, 16'd1999, 16'd1250, 16'd1750,
		16'd1, 16'd32768};

	pulse_width_to_permille DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.pulse_valid    (pulse_valid),
		.pulse_stall    (pulse_stall),
		.pulse_width    (pulse_width),
		.position_valid (position_valid),
		.position_stall (position_stall),
		.position       (position),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	pwp_position_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.pulse_valid       (pulse_valid),
		.pulse_stall       (pulse_stall),
		.pulse_width       (pulse_width),
		.position_valid    (position_valid),
		.position_stall    (position_stall),
		.position          (position),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.position_errors   (position_errors),
		.positions_pending (positions_pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		bit hold_done;
		hold_done      = 1'b0;
		position_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req && !hold_done) begin
				position_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				position_stall <= 1'b0;
				hold_done = 1'b1;
			end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
				position_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				position_stall <= 1'b0;
			end
		end
	end

	task automatic send_pulse(input logic [PW_W-1:0] pw);
		int gap;
		gap = 0;
		if (src_gaps_on && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 19);
		if (gap > 0) begin
			pulse_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pulse_valid <= 1'b1;
		pulse_width <= pw;
		do @(posedge clk); while (pulse_stall);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (positions_pending != 0) @(posedge clk);
	endtask

	task automatic program_scaling(input logic [PW_W-1:0] lo, input logic [PW_W-1:0] hi,
			input logic [DB_W-1:0] db, input bit rv, input bit un);
		cfg_reg_t             idx[5];
		logic [CFG_DATA_W-1:0] val[5];
		idx = '{REG_LOW_WIDTH, REG_HIGH_WIDTH, REG_DEAD_BAND, REG_REVERSE, REG_POS_ONLY};
		val = '{lo, hi, CFG_DATA_W'(db), CFG_DATA_W'(rv), CFG_DATA_W'(un)};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		// let the derived settings settle
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [PW_W-1:0] pick_pulse(logic [PW_W-1:0] lo, logic [PW_W-1:0] hi);
		int a;
		int b;
		int l;
		int h;
		int margin;
		l = int'((lo < hi) ? lo : hi);
		h = int'((lo < hi) ? hi : lo);
		margin = (h - l) / 4 + 2;
		a = (l - margin < 0) ? 0 : l - margin;
		b = (h + margin > 65535) ? 65535 : h + margin;
		case ($urandom_range(0, 15))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return lo;
			3:       return hi;
			4:       return PW_W'((int'(lo) + int'(hi)) / 2 + $urandom_range(0, 2) - 1);
			5, 6:    return PW_W'($urandom_range(0, 65535));
			default: return PW_W'($urandom_range(a, b));
		endcase
	endfunction

	initial begin
		logic [PW_W-1:0] lo;
		logic [PW_W-1:0] hi;
		logic [DB_W-1:0] db;
		bit              rv;
		bit              un;
		int              span;
		int              n;
		arst_n         = 1'b0;
		pulse_valid    = 1'b0;
		pulse_width    = '0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_LOW_WIDTH;
		cfg_data       = '0;
		cycle_count    = 0;
		src_gaps_on    = 1'b1;
		sink_stalls_on = 1'b1;
		long_hold_req  = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		foreach (directed_widths[i])
			send_pulse(directed_widths[i]);
		pulse_valid <= 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			if (ph < 11) begin
				lo = fixed_low[ph];
				hi = fixed_high[ph];
				db = fixed_band[ph];
				rv = fixed_rev[ph];
				un = fixed_uni[ph];
			end else begin
				lo = PW_W'($urandom_range(0, 60000));
				case ($urandom_range(0, 7))
					0:       span = $urandom_range(0, 1);
					1:       span = $urandom_range(2, 65535);
					default: span = $urandom_range(2, 3000);
				endcase
				hi = (int'(lo) + span > 65535) ? 16'hFFFF : PW_W'(int'(lo) + span);
				case ($urandom_range(0, 5))
					0, 1, 2: db = '0;
					3, 4:    db = DB_W'($urandom_range(0, 200));
					default: db = DB_W'($urandom_range(0, 1023));
				endcase
				rv = 1'($urandom_range(0, 1));
				un = 1'($urandom_range(0, 1));
			end
			program_scaling(lo, hi, db, rv, un);

			n = PHASE_REQUESTS;
			src_gaps_on    = (ph % 4 != 1);
			sink_stalls_on = (ph % 4 != 2);
			if (ph == PRESSURE_PHASE) begin
				src_gaps_on   = 1'b0;
				long_hold_req = 1'b1;
				n = 120;
			end
			if (ph >= PHASES - 4) begin
				src_gaps_on    = 1'b0;
				sink_stalls_on = 1'b0;
			end
			repeat (n) send_pulse(pick_pulse(lo, hi));
			pulse_valid <= 1'b0;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (position_errors == 0 && positions_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
